/* rtl/core/wcsr_pkg.sv */
`timescale 1ns / 1ps
package wcsr_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned BPP_SHIFT = 2;   // 4 bytes per pixel

  // configuration register indexes
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd2;
  localparam logic [2:0] REG_VALID_BITS    = 3'd3;
  localparam logic [2:0] REG_COLOR_SELECT  = 3'd4;
  localparam logic [2:0] REG_SCALE_RECIP   = 3'd5;

  // sample formats
  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S8  = 3'd1;
  localparam logic [2:0] FMT_U16 = 3'd2;
  localparam logic [2:0] FMT_S16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;

  localparam logic [2:0] COLOR_YELLOW = 3'd0;
  localparam logic [2:0] COLOR_GREEN  = 3'd1;
  localparam logic [2:0] COLOR_RED    = 3'd2;
  localparam logic [2:0] COLOR_BLUE   = 3'd3;
  localparam logic [2:0] COLOR_WHITE  = 3'd4;

  typedef struct packed {
    logic [12:0] canvas_width;
    logic [12:0] canvas_height;
    logic [2:0]  sample_format;
    logic [4:0]  valid_bits;
    logic [2:0]  color_select;
    logic [16:0] scale_reciprocal;
  } wcsr_cfg_t;

  typedef struct packed {
    logic [7:0] level;
    logic       first;
  } wcsr_level_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] top;
    logic [11:0] bottom;
  } wcsr_span_t;

  function automatic logic [31:0] color_word(input logic [2:0] sel);
    logic [31:0] c;
    case (sel)
      COLOR_YELLOW: c = 32'hff00ff00;
      COLOR_GREEN:  c = 32'h0f0f0f0f;
      COLOR_RED:    c = 32'hf0f0f0f0;
      COLOR_BLUE:   c = 32'h00ff00ff;
      default:      c = 32'hffffffff;
    endcase
    return c;
  endfunction

  // row of a level; clamps to 0 when the canvas is shorter than the level
  function automatic logic [11:0] row_of(input logic [7:0] level, input logic [12:0] height);
    logic [12:0] hm1;
    logic [12:0] diff;
    logic [11:0] r;
    hm1  = height - 13'd1;
    diff = hm1 - {5'd0, level};
    if (height == 13'd0 || hm1 < {5'd0, level}) begin
      r = 12'd0;
    end else begin
      r = diff[12:1];
    end
    return r;
  endfunction

endpackage

/* rtl/core/wcsr_level.sv */
`timescale 1ns / 1ps
module wcsr_level import wcsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wcsr_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_raw,
  input  logic        in_first,
  output logic        lvl_valid,
  input  logic        lvl_ready,
  output wcsr_level_t lvl
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_value_r;
  logic        s1_first_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic [7:0]  s2_level_r;
  logic        s2_first_r;

  logic        s1_ready, s2_ready;
  logic [31:0] fmt_mask, offset, masked, value;
  logic [4:0]  shift;
  logic        is_signed;
  logic [48:0] prod;
  logic [7:0]  level;

  assign s2_ready = !s2_valid_r || lvl_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    case (cfg.sample_format)
      FMT_U8, FMT_S8:   fmt_mask = 32'h0000_00ff;
      FMT_U16, FMT_S16: fmt_mask = 32'h0000_ffff;
      default:          fmt_mask = 32'hffff_ffff;
    endcase
    is_signed = (cfg.sample_format == FMT_S8) || (cfg.sample_format == FMT_S16) ||
                (cfg.sample_format == FMT_S32);
    shift  = cfg.valid_bits - 5'd1;
    offset = 32'd1 << shift;
    masked = in_raw & fmt_mask;
    if (is_signed && cfg.valid_bits != 5'd0) begin
      value = (masked + offset) & fmt_mask;
    end else begin
      value = masked;
    end
  end

  // Q1.16 scale, saturate to 8 bits
  always_comb begin
    prod = 49'(s1_value_r) * 49'(cfg.scale_reciprocal);
    if (prod[48:24] != 25'd0) begin
      level = 8'hff;
    end else begin
      level = prod[23:16];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) s1_valid_nxt = in_valid;
    s2_valid_nxt = s2_valid_r;
    if (s2_ready) s2_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_value_r <= value;
      s1_first_r <= in_first;
    end
    if (s2_ready && s1_valid_r) begin
      s2_level_r <= level;
      s2_first_r <= s1_first_r;
    end
  end

  assign lvl_valid = s2_valid_r;
  assign lvl.level = s2_level_r;
  assign lvl.first = s2_first_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_value_r) && $stable(s1_first_r))
    else $error("stage 1 lost or changed a held sample");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !lvl_ready |=> s2_valid_r && $stable(s2_level_r))
    else $error("stage 2 lost or changed a held level");

endmodule

/* rtl/core/wcsr_span.sv */
`timescale 1ns / 1ps
module wcsr_span import wcsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wcsr_cfg_t   cfg,
  input  logic        lvl_valid,
  output logic        lvl_ready,
  input  wcsr_level_t lvl,
  output logic        span_valid,
  input  logic        span_ready,
  output wcsr_span_t  span
);

  logic [7:0]  prev_level_r;
  logic [11:0] col_cnt_r, col_cnt_nxt;
  logic        s3_valid_r, s3_valid_nxt;
  wcsr_span_t  s3_r;

  logic        take, emit;
  logic [7:0]  last, hi, lo;
  logic [11:0] col_cur, limit;
  logic [12:0] w_lim;
  wcsr_span_t  span_nxt;

  assign lvl_ready = !s3_valid_r || span_ready;
  assign take      = lvl_valid && lvl_ready;

  always_comb begin
    last    = lvl.first ? lvl.level : prev_level_r;
    col_cur = lvl.first ? 12'd0 : col_cnt_r;
    w_lim   = (cfg.canvas_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : cfg.canvas_width;
    limit   = w_lim[12:1];
    emit    = col_cur < limit;
    hi      = (lvl.level >= last) ? lvl.level : last;
    lo      = (lvl.level >= last) ? last : lvl.level;
    span_nxt.col    = col_cur;
    span_nxt.top    = row_of(hi, cfg.canvas_height);
    span_nxt.bottom = row_of(lo, cfg.canvas_height);
    col_cnt_nxt = emit ? col_cur + 12'd1 : col_cur;
    s3_valid_nxt = s3_valid_r;
    if (take) begin
      s3_valid_nxt = emit;
    end else if (span_ready) begin
      s3_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 8'd0;
      col_cnt_r    <= 12'd0;
      s3_valid_r   <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
      if (take) begin
        prev_level_r <= lvl.level;
        col_cnt_r    <= col_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) s3_r <= span_nxt;
  end

  assign span_valid = s3_valid_r;
  assign span       = s3_r;

  a_top_above: assert property (@(posedge clk) disable iff (!rst_n)
    take && emit |=> s3_r.top <= s3_r.bottom)
    else $error("span top row below bottom row");

  a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    take && lvl.first && limit != 12'd0 |=> s3_valid_r && s3_r.col == 12'd0)
    else $error("first sample did not restart at column 0");

endmodule

/* rtl/core/wcsr_addr.sv */
`timescale 1ns / 1ps
module wcsr_addr import wcsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wcsr_cfg_t   cfg,
  input  logic        span_valid,
  output logic        span_ready,
  input  wcsr_span_t  span,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [95:0] out_data
);

  logic        out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;
  logic [24:0] prod;
  logic [25:0] lin, addr;

  assign span_ready = !out_valid_r || out_ready;

  always_comb begin
    prod = 25'(span.top) * 25'(cfg.canvas_width);
    lin  = 26'(prod) + 26'(span.col);
    addr = lin << BPP_SHIFT;
    out_data_nxt = {5'd0, color_word(cfg.color_select), addr,
                    span.bottom[10:0], span.top[10:0], span.col[10:0]};
    out_valid_nxt = out_valid_r;
    if (span_ready) out_valid_nxt = span_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (span_valid && span_ready) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_span_drain: assert property (@(posedge clk) disable iff (!rst_n)
    span_valid && span_ready |=> out_valid_r)
    else $error("span transfer did not load the output register");

endmodule

/* rtl/core/waveform_column_span_renderer_top.sv */
`timescale 1ns / 1ps
// Waveform column span renderer.
// in_*  : one raw sample per transfer. in_tdata = raw sample, in_tuser = first-sample
//         flag (restarts the trace at column 0, previous level taken as current).
// out_* : at most one span per sample: column, top and bottom row, byte address of
//         the top pixel and the color word. Samples past min(width, 4096)/2 columns
//         are consumed without a result.
// cfg_* : register writes (width, height, format, valid bits, color, reciprocal),
//         taken in the cycle cfg_we is high; write only while the block is idle.
// Throughput is one sample per clock while out_tready stays high. The stages run from
// the input transfer to out_tvalid: mask/offset, reciprocal multiply, level compare
// and rows, then the row-times-width multiply into the output register.
// Each stage holds its data while the next one is full, so out_tready low fills
// the pipe up to four samples before in_tready drops; bubbles close up.
// Reset (rst_n low, synchronous) empties the pipe, zeroes the previous level and
// the column count, and loads the register defaults.
module waveform_column_span_renderer_top import wcsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] raw_sample
  input  logic        in_tuser,   // [0] first_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] column, [21:11] row_top, [32:22] row_bottom, [58:33] top_address,
  // [90:59] pixel_color, [95:91] zero
  output logic [95:0] out_tdata
);

  wcsr_cfg_t   cfg_r;
  logic        lvl_valid, lvl_ready, span_valid, span_ready;
  wcsr_level_t lvl;
  wcsr_span_t  span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.canvas_width     <= 13'd1024;
      cfg_r.canvas_height    <= 13'd512;
      cfg_r.sample_format    <= FMT_U8;
      cfg_r.valid_bits       <= 5'd8;
      cfg_r.color_select     <= COLOR_WHITE;
      cfg_r.scale_reciprocal <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  cfg_r.canvas_width     <= cfg_wdata[12:0];
        REG_CANVAS_HEIGHT: cfg_r.canvas_height    <= cfg_wdata[12:0];
        REG_SAMPLE_FORMAT: cfg_r.sample_format    <= cfg_wdata[2:0];
        REG_VALID_BITS:    cfg_r.valid_bits       <= cfg_wdata[4:0];
        REG_COLOR_SELECT:  cfg_r.color_select     <= cfg_wdata[2:0];
        REG_SCALE_RECIP:   cfg_r.scale_reciprocal <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wcsr_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_raw    (in_tdata),
    .in_first  (in_tuser),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl)
  );

  wcsr_span u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .lvl_valid  (lvl_valid),
    .lvl_ready  (lvl_ready),
    .lvl        (lvl),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span)
  );

  wcsr_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

/* test/waveform_column_span_renderer_top_tb.sv */
`timescale 1ns / 1ps
module waveform_column_span_renderer_top_tb;
  import wcsr_pkg::*;

  // codes the package leaves unnamed
  localparam logic [2:0] FMT_U32      = 3'd5;
  localparam logic [2:0] FMT_ALT6     = 3'd6;
  localparam logic [2:0] FMT_ALT7     = 3'd7;
  localparam logic [2:0] COLOR_UNUSED = 3'd7;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row_top;
    logic [10:0] row_bottom;
    logic [25:0] top_address;
    logic [31:0] pixel_color;
  } span_t;

  class span_scoreboard;
    logic [12:0] width;
    logic [12:0] height;
    logic [2:0]  fmt;
    logic [4:0]  vbits;
    logic [2:0]  color;
    logic [16:0] recip;
    logic [7:0]  prev_level;
    logic [11:0] col_count;
    span_t       pending[$];
    int          errors;
    int          samples_seen;
    int          spans_seen;

    function new();
      width        = 13'd1024;
      height       = 13'd512;
      fmt          = FMT_U8;
      vbits        = 5'd8;
      color        = COLOR_WHITE;
      recip        = 17'd65536;
      prev_level   = 8'd0;
      col_count    = 12'd0;
      errors       = 0;
      samples_seen = 0;
      spans_seen   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] val);
      case (idx)
        REG_CANVAS_WIDTH:  width = val[12:0];
        REG_CANVAS_HEIGHT: height = val[12:0];
        REG_SAMPLE_FORMAT: fmt = val[2:0];
        REG_VALID_BITS:    vbits = val[4:0];
        REG_COLOR_SELECT:  color = val[2:0];
        REG_SCALE_RECIP:   recip = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] level_of(logic [31:0] raw);
      logic [31:0] mask;
      logic [31:0] v;
      logic [31:0] offset;
      logic [63:0] prod;
      if (fmt <= FMT_S8) begin
        mask = 32'h0000_00ff;
      end else if (fmt <= FMT_S16) begin
        mask = 32'h0000_ffff;
      end else begin
        mask = 32'hffff_ffff;
      end
      v = raw & mask;
      if ((fmt == FMT_S8 || fmt == FMT_S16 || fmt == FMT_S32) && vbits != 5'd0) begin
        offset = 32'd1 << (vbits - 5'd1);
        v = (v + offset) & mask;
      end
      prod = (64'(v) * 64'(recip)) >> 16;
      return (prod > 64'd255) ? 8'hff : prod[7:0];
    endfunction

    // short or empty canvas clamps the row to 0
    function int unsigned row_for(logic [7:0] level);
      int unsigned hm1;
      if (height == 13'd0) return 0;
      hm1 = int'(height) - 1;
      if (hm1 < level) return 0;
      return (hm1 - level) >> 1;
    endfunction

    function void note_sample(logic [31:0] raw, logic first);
      logic [7:0]  level;
      logic [7:0]  last;
      logic [7:0]  hi;
      logic [7:0]  lo;
      int unsigned limit;
      int unsigned top;
      logic [63:0] addr;
      span_t       s;
      samples_seen++;
      level = level_of(raw);
      if (first) begin
        col_count = 12'd0;
        last = level;
      end else begin
        last = prev_level;
      end
      prev_level = level;
      limit = (width > MAX_WIDTH) ? MAX_WIDTH : width;
      limit = limit >> 1;
      if (col_count >= limit) return;
      hi  = (level >= last) ? level : last;
      lo  = (level >= last) ? last : level;
      top = row_for(hi);
      addr = (64'(col_count) + 64'(top) * 64'(width)) * 64'd4;
      s.column      = col_count[10:0];
      s.row_top     = top[10:0];
      s.row_bottom  = 11'(row_for(lo));
      s.top_address = addr[25:0];
      case (color)
        COLOR_YELLOW: s.pixel_color = 32'hff00ff00;
        COLOR_GREEN:  s.pixel_color = 32'h0f0f0f0f;
        COLOR_RED:    s.pixel_color = 32'hf0f0f0f0;
        COLOR_BLUE:   s.pixel_color = 32'h00ff00ff;
        default:      s.pixel_color = 32'hffffffff;
      endcase
      pending.push_back(s);
      col_count = col_count + 12'd1;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_span(logic [95:0] d);
      span_t s;
      if (pending.size() == 0) begin
        $error("span transfer with nothing expected: 0x%0h", d);
        errors++;
        return;
      end
      s = pending.pop_front();
      spans_seen++;
      cmp_field("column", 32'(s.column), 32'(d[10:0]));
      cmp_field("row_top", 32'(s.row_top), 32'(d[21:11]));
      cmp_field("row_bottom", 32'(s.row_bottom), 32'(d[32:22]));
      cmp_field("top_address", 32'(s.top_address), 32'(d[58:33]));
      cmp_field("pixel_color", s.pixel_color, d[90:59]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [16:0] cfg_wdata = 17'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  span_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    ready_run = 0;
  int unsigned    ready_kind = 0;
  int             settings_used = 0;

  waveform_column_span_renderer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of always-ready, random, mostly-stalled and fully stalled
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_run  = $urandom_range(1, 40);
      ready_kind = $urandom_range(0, 3);
    end
    ready_run--;
    case (ready_kind)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_span(out_tdata);
  end

  task automatic send_sample(input logic [31:0] raw, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 50);
      if (gap > 0) begin
        if (in_tvalid) in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(raw, first);
    @(negedge clk);
  endtask

  // wait out every expected span plus the pipe depth, since dropped
  // samples may still be in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic [12:0] w, input logic [12:0] h, input logic [2:0] f,
                           input logic [4:0] vb, input logic [2:0] c, input logic [16:0] r);
    logic [16:0] vals[6];
    int          i;
    vals[0] = 17'(w);
    vals[1] = 17'(h);
    vals[2] = 17'(f);
    vals[3] = 17'(vb);
    vals[4] = 17'(c);
    vals[5] = r;
    drain();
    for (i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic random_phase(input int unsigned n_items);
    logic [12:0] w;
    logic [12:0] h;
    logic [2:0]  f;
    logic [4:0]  vb;
    logic [2:0]  c;
    logic [16:0] r;
    logic [31:0] raw;
    int unsigned i;
    case ($urandom_range(0, 7))
      0: w = 13'($urandom_range(2, 40));
      1: w = 13'($urandom_range(4097, 8191));
      default: w = 13'($urandom_range(2, 4096));
    endcase
    h  = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, 8191))
                                     : 13'($urandom_range(256, 4096));
    f  = 3'($urandom_range(0, 7));
    vb = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
    c  = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0: r = 17'($urandom_range(0, 131071));
      1: r = 17'd1 << $urandom_range(0, 16);
      default: r = 17'($urandom_range(60000, 70000));
    endcase
    configure(w, h, f, vb, c, r);
    for (i = 0; i < n_items; i++) begin
      raw = $urandom;
      // spread magnitudes so every level range shows up
      if ($urandom_range(0, 9) < 7) raw = raw >> $urandom_range(0, 31);
      send_sample(raw, (i == 0) || ($urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults, trace starts without a first-sample flag
    send_sample(32'h0000_0012, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_00ff, 1'b0);
    // signed 8-bit, offset wraps
    configure(13'd1024, 13'd512, FMT_S8, 5'd8, COLOR_YELLOW, 17'd65536);
    send_sample(32'h0000_0080, 1'b1);
    send_sample(32'h0000_007f, 1'b0);
    send_sample(32'hffff_ff00, 1'b0);
    // zero valid bits: no offset
    configure(13'd640, 13'd480, FMT_S16, 5'd0, COLOR_GREEN, 17'd256);
    send_sample(32'h0000_8000, 1'b1);
    send_sample(32'h0000_ffff, 1'b0);
    // wide valid bits on 32-bit signed, smallest nonzero reciprocal
    configure(13'd4096, 13'd4096, FMT_S32, 5'd31, COLOR_RED, 17'd1);
    send_sample(32'hc000_0000, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    // zero reciprocal, oversized canvas, format six
    configure(13'd8191, 13'd8191, FMT_ALT6, 5'd16, COLOR_BLUE, 17'd0);
    send_sample(32'hffff_ffff, 1'b1);
    send_sample(32'h0000_0001, 1'b0);
    // short canvas, unknown color, format seven, largest reciprocal
    configure(13'd300, 13'd100, FMT_ALT7, 5'd5, COLOR_UNUSED, 17'd131071);
    send_sample(32'h00ff_ffff, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    // a single column then the count holds; zero height
    configure(13'd2, 13'd0, FMT_U16, 5'd16, COLOR_WHITE, 17'd65536);
    send_sample(32'h0000_0005, 1'b1);
    send_sample(32'h0000_0006, 1'b0);
    send_sample(32'h0000_0007, 1'b0);
    // no columns at all
    configure(13'd0, 13'd256, FMT_U32, 5'd1, COLOR_YELLOW, 17'd65536);
    send_sample(32'h0000_0008, 1'b1);
    send_sample(32'h0000_0009, 1'b0);

    repeat (8) random_phase(225);
    drain();

    $display("covered %0d samples over %0d register settings; %0d spans checked",
             sb.samples_seen, settings_used + 1, sb.spans_seen);
    $display("all formats, offsets, reciprocal and canvas extremes, with random stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("waveform_column_span_renderer_top_tb: done, clean");
    end else begin
      $display("waveform_column_span_renderer_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d spans still expected", sb.pending.size());
    $display("waveform_column_span_renderer_top_tb: done, errors");
    $finish;
  end

endmodule
